// ===== hdl/spd_pkg.sv =====
// Shared types, constants and helpers for the sensor packet deframer.
// Used by every module of the block; depends on nothing.
package spd_pkg;

  localparam int PACKET_BYTES = 20;
  // The window keeps the bytes that came before the newest one.
  localparam int HIST_BYTES = PACKET_BYTES - 1;
  localparam int FILL_W = $clog2(PACKET_BYTES);

  // Fixed header bytes and field ids with their positions in the packet.
  localparam logic [7:0] HDR_SYNC = 8'd19;
  localparam logic [7:0] HDR_LEN = 8'd17;
  localparam logic [7:0] ID_LEFT = 8'd28;
  localparam logic [7:0] ID_FRONT_LEFT = 8'd29;
  localparam logic [7:0] ID_FRONT_RIGHT = 8'd30;
  localparam logic [7:0] ID_RIGHT = 8'd31;
  localparam logic [7:0] ID_DIST = 8'd19;
  localparam logic [7:0] ID_IR = 8'd17;

  localparam int POS_SYNC = 0;
  localparam int POS_LEN = 1;
  localparam int POS_ID_LEFT = 2;
  localparam int POS_LEFT = 3;
  localparam int POS_ID_FRONT_LEFT = 5;
  localparam int POS_FRONT_LEFT = 6;
  localparam int POS_ID_FRONT_RIGHT = 8;
  localparam int POS_FRONT_RIGHT = 9;
  localparam int POS_ID_RIGHT = 11;
  localparam int POS_RIGHT = 12;
  localparam int POS_ID_DIST = 14;
  localparam int POS_DIST = 15;
  localparam int POS_ID_IR = 17;
  localparam int POS_IR = 18;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_MISALIGNED = 1'b1;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LEFT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_FRONT_LEFT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_FRONT_RIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BIT_VALUE = 3'd4;

  typedef struct packed {
    logic [15:0] threshold_left;
    logic [15:0] threshold_front_left;
    logic [15:0] threshold_front_right;
    logic [15:0] threshold_right;
    logic        high_bit_value;
  } cfg_t;

  typedef struct packed {
    logic               status;
    logic [15:0]        left_reading;
    logic [15:0]        front_left_reading;
    logic [15:0]        front_right_reading;
    logic [15:0]        right_reading;
    logic [3:0]         edge_bits;
    logic signed [15:0] travel;
    logic [7:0]         remote_code;
    logic [2:0]         lamp_bits;
    logic [15:0]        packet_index;
  } result_t;

  function automatic logic edge_bit(logic [15:0] reading, logic [15:0] limit, logic hi);
    return (reading > limit) ? hi : ~hi;
  endfunction

endpackage

// ===== hdl/spd_if.sv =====
// Valid/ready channel interfaces for the byte stream and the decoded results.
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface spd_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [15:0]        left_reading;
  logic [15:0]        front_left_reading;
  logic [15:0]        front_right_reading;
  logic [15:0]        right_reading;
  logic [3:0]         edge_bits;
  logic signed [15:0] travel;
  logic [7:0]         remote_code;
  logic [2:0]         lamp_bits;
  logic [15:0]        packet_index;

  modport source (output valid, output status, output left_reading,
                  output front_left_reading, output front_right_reading,
                  output right_reading, output edge_bits, output travel,
                  output remote_code, output lamp_bits, output packet_index,
                  input ready);
  modport sink (input valid, input status, input left_reading,
                input front_left_reading, input front_right_reading,
                input right_reading, input edge_bits, input travel,
                input remote_code, input lamp_bits, input packet_index,
                output ready);
endinterface

// ===== hdl/spd_cfg.sv =====
// Configuration register file: cliff thresholds and the high bit value.
// Depends on spd_pkg.
module spd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0] cfg_data,
  output spd_pkg::cfg_t                  cfg
);
  import spd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_left <= '0;
      cfg.threshold_front_left <= '0;
      cfg.threshold_front_right <= '0;
      cfg.threshold_right <= '0;
      cfg.high_bit_value <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_THRESHOLD_LEFT: cfg.threshold_left <= cfg_data;
        REG_THRESHOLD_FRONT_LEFT: cfg.threshold_front_left <= cfg_data;
        REG_THRESHOLD_FRONT_RIGHT: cfg.threshold_front_right <= cfg_data;
        REG_THRESHOLD_RIGHT: cfg.threshold_right <= cfg_data;
        REG_HIGH_BIT_VALUE: cfg.high_bit_value <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/spd_frame.sv =====
// Byte window, running checksum, frame check and field decode.
// Depends on spd_pkg.
module spd_frame (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  spd_pkg::cfg_t    cfg,
  output logic             res_valid,
  output spd_pkg::result_t res
);
  import spd_pkg::*;

  // hist holds the last HIST_BYTES bytes, oldest at index 0. The live window is
  // the newest fill_count of them; when the incoming byte completes a packet,
  // hist plus that byte is the whole packet.
  logic [7:0]        hist [HIST_BYTES];
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] fill_count_next;
  logic [7:0]        run_sum;
  logic [7:0]        run_sum_next;
  logic [15:0]       accepted_count;
  logic [15:0]       accepted_count_next;

  logic [7:0] pkt [PACKET_BYTES];
  logic [7:0] total;
  logic       full_now;
  logic       hdr_ok;
  logic       match;
  logic       b_l, b_fl, b_fr, b_r;
  logic [15:0] rd_l, rd_fl, rd_fr, rd_r;

  always_comb begin
    for (int k = 0; k < HIST_BYTES; k++) begin
      pkt[k] = hist[k];
    end
    pkt[HIST_BYTES] = in_byte;
  end

  assign full_now = (fill_count == FILL_W'(HIST_BYTES));
  assign total = run_sum + in_byte;
  assign hdr_ok = (pkt[POS_SYNC] == HDR_SYNC) && (pkt[POS_LEN] == HDR_LEN) &&
                  (pkt[POS_ID_LEFT] == ID_LEFT) &&
                  (pkt[POS_ID_FRONT_LEFT] == ID_FRONT_LEFT) &&
                  (pkt[POS_ID_FRONT_RIGHT] == ID_FRONT_RIGHT) &&
                  (pkt[POS_ID_RIGHT] == ID_RIGHT) &&
                  (pkt[POS_ID_DIST] == ID_DIST) && (pkt[POS_ID_IR] == ID_IR);
  assign match = hdr_ok && (total == 8'd0);

  assign rd_l = {pkt[POS_LEFT], pkt[POS_LEFT+1]};
  assign rd_fl = {pkt[POS_FRONT_LEFT], pkt[POS_FRONT_LEFT+1]};
  assign rd_fr = {pkt[POS_FRONT_RIGHT], pkt[POS_FRONT_RIGHT+1]};
  assign rd_r = {pkt[POS_RIGHT], pkt[POS_RIGHT+1]};
  assign b_l = edge_bit(rd_l, cfg.threshold_left, cfg.high_bit_value);
  assign b_fl = edge_bit(rd_fl, cfg.threshold_front_left, cfg.high_bit_value);
  assign b_fr = edge_bit(rd_fr, cfg.threshold_front_right, cfg.high_bit_value);
  assign b_r = edge_bit(rd_r, cfg.threshold_right, cfg.high_bit_value);

  assign res_valid = accept && full_now;

  always_comb begin
    res = '0;
    if (match) begin
      res.status = STATUS_OK;
      res.left_reading = rd_l;
      res.front_left_reading = rd_fl;
      res.front_right_reading = rd_fr;
      res.right_reading = rd_r;
      res.edge_bits = {b_l, b_fl, b_fr, b_r};
      res.travel = {pkt[POS_DIST], pkt[POS_DIST+1]};
      res.remote_code = pkt[POS_IR];
      res.lamp_bits = {b_l, b_fl | b_fr, b_r};
      res.packet_index = accepted_count;
    end else begin
      res.status = STATUS_MISALIGNED;
    end
  end

  always_comb begin
    fill_count_next = fill_count;
    run_sum_next = run_sum;
    accepted_count_next = accepted_count;
    if (accept) begin
      if (!full_now) begin
        fill_count_next = fill_count + 1'b1;
        run_sum_next = total;
      end else if (match) begin
        fill_count_next = '0;
        run_sum_next = '0;
        accepted_count_next = accepted_count + 1'b1;
      end else begin
        // The oldest byte leaves the window and its share of the sum with it.
        fill_count_next = FILL_W'(HIST_BYTES);
        run_sum_next = total - hist[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      run_sum <= '0;
      accepted_count <= '0;
    end else begin
      fill_count <= fill_count_next;
      run_sum <= run_sum_next;
      accepted_count <= accepted_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < HIST_BYTES - 1; k++) begin
        hist[k] <= hist[k+1];
      end
      hist[HIST_BYTES-1] <= in_byte;
    end
  end

`ifndef SYNTHESIS
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (fill_count != FILL_W'(HIST_BYTES))) |-> !res_valid)
    else $error("result produced before the window was full");

  a_ok_clears: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == STATUS_OK)) |=>
      ((fill_count == '0) && (run_sum == 8'd0) &&
       (accepted_count == $past(accepted_count) + 16'd1)))
    else $error("accepted packet did not empty the window and count");

  a_slip_keeps: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == STATUS_MISALIGNED)) |=>
      ((fill_count == FILL_W'(HIST_BYTES)) && $stable(accepted_count)))
    else $error("misaligned window did not drop exactly one byte");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(HIST_BYTES))
    else $error("fill count beyond the window");
`endif

endmodule

// ===== hdl/spd_skid.sv =====
// Two-entry result buffer: output register plus skid register, so the
// upstream ready comes from a flop. Depends on spd_pkg and spd_out_if.
module spd_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  spd_pkg::result_t push_data,
  output logic             push_ready,
  spd_out_if.source        res_ch
);
  import spd_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign push_ready = !skid_valid;
  assign pop = main_valid && res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push_valid;
      end
    end else if (push_valid && main_valid) begin
      skid_valid <= 1'b1;
    end else if (push_valid) begin
      main_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      main_data <= skid_data;
    end else if (push_valid && (pop || !main_valid)) begin
      main_data <= push_data;
    end
    if (push_valid && main_valid && !pop) begin
      skid_data <= push_data;
    end
  end

  assign res_ch.valid = main_valid;
  assign res_ch.status = main_data.status;
  assign res_ch.left_reading = main_data.left_reading;
  assign res_ch.front_left_reading = main_data.front_left_reading;
  assign res_ch.front_right_reading = main_data.front_right_reading;
  assign res_ch.right_reading = main_data.right_reading;
  assign res_ch.edge_bits = main_data.edge_bits;
  assign res_ch.travel = main_data.travel;
  assign res_ch.remote_code = main_data.remote_code;
  assign res_ch.lamp_bits = main_data.lamp_bits;
  assign res_ch.packet_index = main_data.packet_index;

endmodule

// ===== hdl/sensor_packet_deframer_core.sv =====
// Sensor packet deframer: one received byte accepted per cycle while rx_ch.ready is high.
// The result for the byte that fills the window is registered in the output buffer, which drives res_ch.
// The window shift and the running checksum update together on each accepted byte.
// Results leave through a two-entry output buffer; rx_ch.ready drops only when both are full.
// Reset (rst, synchronous) empties the window, clears the packet count and loads the
// register defaults: thresholds 0, high bit value 1.
module sensor_packet_deframer_core (
  input  logic                           clk,
  input  logic                           rst,
  spd_in_if.sink                         rx_ch,
  spd_out_if.source                      res_ch,
  input  logic                           cfg_wr_en,
  input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spd_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;
  logic    push_ready;
  logic    accept;

  assign rx_ch.ready = push_ready;
  assign accept = rx_ch.valid && push_ready;

  spd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spd_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (rx_ch.rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  spd_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (push_ready),
    .res_ch     (res_ch)
  );

endmodule
